[hw/rtl/minv_pkg.sv]
// minv_pkg: shared constants for the 3x3 adjugate matrix inverse
// holds the cofactor index table and fixed field widths; no dependencies
package minv_pkg;

  localparam int unsigned NUM_ELEM = 9;
  localparam int unsigned THR_WIDTH = 32;
  localparam logic [THR_WIDTH-1:0] THR_RESET = 32'd281;
  localparam int unsigned FRONT_LAT = 4;

  // element k of the adjugate: m[p]*m[q] - m[r]*m[s], index = row*3+col
  localparam logic [3:0] COF_IDX [NUM_ELEM][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

endpackage

[hw/rtl/matrix_inverse_3x3_core.sv]
// matrix_inverse_3x3_core: top level of the streaming 3x3 matrix inverse
// depends on minv_pkg, minv_front and minv_div_lane
//
// Streaming inverse of a 3x3 matrix by the adjugate method. One transaction on the
// input carries nine signed fixed-point entries (FRAC_BITS fraction bits); one
// transaction on the output carries the nine inverse entries, rounded to nearest
// with ties away from zero and saturated, plus the singular and overflow flags.
// The block takes a new matrix every clock cycle while the output is not stalled.
// Four stages build the cofactors and the exact determinant, nine division lanes
// (one per inverse entry) each resolve one quotient bit per stage over
// DATA_WIDTH + 1 stages and round in one more, and a merging stage applies the
// singular test and collects the overflow flags. When out_ready is low with a
// result waiting, the whole pipeline holds and in_ready drops. The singular
// threshold is compared against the determinant magnitude in units of
// 2^-(3*FRAC_BITS); it resets to 281, and the user must write it through
// cfg_wr_en/cfg_wr_data only while idle; the block does not enforce this.
module matrix_inverse_3x3_core #(
  parameter int DATA_WIDTH = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [minv_pkg::THR_WIDTH-1:0]      cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [DATA_WIDTH-1:0]        a00,
  input  logic signed [DATA_WIDTH-1:0]        a01,
  input  logic signed [DATA_WIDTH-1:0]        a02,
  input  logic signed [DATA_WIDTH-1:0]        a10,
  input  logic signed [DATA_WIDTH-1:0]        a11,
  input  logic signed [DATA_WIDTH-1:0]        a12,
  input  logic signed [DATA_WIDTH-1:0]        a20,
  input  logic signed [DATA_WIDTH-1:0]        a21,
  input  logic signed [DATA_WIDTH-1:0]        a22,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [DATA_WIDTH-1:0]        r00,
  output logic signed [DATA_WIDTH-1:0]        r01,
  output logic signed [DATA_WIDTH-1:0]        r02,
  output logic signed [DATA_WIDTH-1:0]        r10,
  output logic signed [DATA_WIDTH-1:0]        r11,
  output logic signed [DATA_WIDTH-1:0]        r12,
  output logic signed [DATA_WIDTH-1:0]        r20,
  output logic signed [DATA_WIDTH-1:0]        r21,
  output logic signed [DATA_WIDTH-1:0]        r22,
  output logic                                singular,
  output logic                                overflow
);

  localparam int NE       = minv_pkg::NUM_ELEM;
  localparam int LANE_LAT = DATA_WIDTH + 2;
  localparam int TOT_LAT  = minv_pkg::FRONT_LAT + LANE_LAT + 1;

  logic [minv_pkg::THR_WIDTH-1:0] singular_threshold;

  logic                          en;
  logic signed [DATA_WIDTH-1:0]  a_in  [NE];
  logic [2*DATA_WIDTH-1:0]       cmag  [NE];
  logic                          cneg  [NE];
  logic [3*DATA_WIDTH-1:0]       dmag;
  logic                          dneg;
  logic                          sing_front;
  logic [DATA_WIDTH-1:0]         lane_res [NE];
  logic                          lane_ovf [NE];
  logic                          sing_pipe [LANE_LAT];
  logic [TOT_LAT-1:0]            vld;
  logic signed [DATA_WIDTH-1:0]  res_q [NE];
  logic                          any_ovf;

  // whole pipeline moves unless a finished transaction is held at the output
  assign en        = !vld[TOT_LAT-1] || out_ready;
  // no transaction is taken while in reset
  assign in_ready  = en && !rst;
  assign out_valid = vld[TOT_LAT-1];

  assign a_in = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      singular_threshold <= minv_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      singular_threshold <= cfg_wr_data;
    end
  end

  // valid bit per pipeline stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOT_LAT-2:0], in_valid};
    end
  end

  // cofactors and determinant, shared by all lanes
  minv_front #(
    .DW (DATA_WIDTH)
  ) u_front (
    .clk       (clk),
    .en        (en),
    .threshold (singular_threshold),
    .a         (a_in),
    .cmag      (cmag),
    .cneg      (cneg),
    .dmag      (dmag),
    .dneg      (dneg),
    .singular  (sing_front)
  );

  // one division lane per inverse entry
  for (genvar k = 0; k < NE; k++) begin : g_lane
    minv_div_lane #(
      .DW (DATA_WIDTH),
      .FW (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .en   (en),
      .cmag (cmag[k]),
      .cneg (cneg[k]),
      .dmag (dmag),
      .dneg (dneg),
      .res  (lane_res[k]),
      .ovf  (lane_ovf[k])
    );
  end

  // singular flag travels alongside the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      sing_pipe[0] <= sing_front;
      for (int s = 1; s < LANE_LAT; s++) begin
        sing_pipe[s] <= sing_pipe[s-1];
      end
    end
  end

  always_comb begin
    any_ovf = 1'b0;
    for (int k = 0; k < NE; k++) begin
      any_ovf = any_ovf | lane_ovf[k];
    end
  end

  // merging stage: a singular matrix gives zeros and no overflow
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NE; k++) begin
        res_q[k] <= sing_pipe[LANE_LAT-1] ? '0 : $signed(lane_res[k]);
      end
      singular <= sing_pipe[LANE_LAT-1];
      overflow <= !sing_pipe[LANE_LAT-1] && any_ovf;
    end
  end

  assign r00 = res_q[0];
  assign r01 = res_q[1];
  assign r02 = res_q[2];
  assign r10 = res_q[3];
  assign r11 = res_q[4];
  assign r12 = res_q[5];
  assign r20 = res_q[6];
  assign r21 = res_q[7];
  assign r22 = res_q[8];

endmodule

[hw/rtl/minv_front.sv]
// minv_front: cofactors, determinant and singular test, four register stages
// depends on minv_pkg
module minv_front #(
  parameter int DW = 24
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [minv_pkg::THR_WIDTH-1:0]   threshold,
  input  logic signed [DW-1:0]             a     [minv_pkg::NUM_ELEM],
  output logic [2*DW-1:0]                  cmag  [minv_pkg::NUM_ELEM],
  output logic                             cneg  [minv_pkg::NUM_ELEM],
  output logic [3*DW-1:0]                  dmag,
  output logic                             dneg,
  output logic                             singular
);

  localparam int CFW  = 2*DW + 1;
  localparam int DETW = 3*DW + 3;
  localparam int DMW  = 3*DW;

  logic signed [CFW-1:0]  cof_c [minv_pkg::NUM_ELEM];
  logic signed [CFW-1:0]  cof1  [minv_pkg::NUM_ELEM];
  logic signed [DW-1:0]   row1  [3];
  logic signed [CFW-1:0]  pl2   [3];
  logic signed [CFW-1:0]  ph2   [3];
  logic [2*DW-1:0]        cmag2 [minv_pkg::NUM_ELEM];
  logic                   cneg2 [minv_pkg::NUM_ELEM];
  logic [2*DW-1:0]        cmag3 [minv_pkg::NUM_ELEM];
  logic                   cneg3 [minv_pkg::NUM_ELEM];
  logic signed [DETW-1:0] det3;
  logic signed [DETW-1:0] det_c;
  logic [DETW-1:0]        dabs_c;

  always_comb begin
    for (int k = 0; k < minv_pkg::NUM_ELEM; k++) begin
      cof_c[k] = CFW'(a[minv_pkg::COF_IDX[k][0]] * a[minv_pkg::COF_IDX[k][1]])
               - CFW'(a[minv_pkg::COF_IDX[k][2]] * a[minv_pkg::COF_IDX[k][3]]);
    end
  end

  // determinant from the first adjugate column and row 0
  always_comb begin
    det_c = '0;
    for (int k = 0; k < 3; k++) begin
      det_c = det_c + (DETW'(ph2[k]) <<< DW) + DETW'(pl2[k]);
    end
  end

  assign dabs_c = det3[DETW-1] ? DETW'(-det3) : DETW'(det3);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < minv_pkg::NUM_ELEM; k++) begin
        cof1[k]  <= cof_c[k];
        cneg2[k] <= cof1[k][CFW-1];
        cmag2[k] <= cof1[k][CFW-1] ? (2*DW)'(-cof1[k]) : (2*DW)'(cof1[k]);
        cmag3[k] <= cmag2[k];
        cneg3[k] <= cneg2[k];
        cmag[k]  <= cmag3[k];
        cneg[k]  <= cneg3[k];
      end
      for (int k = 0; k < 3; k++) begin
        row1[k] <= a[k];
        // split the cofactor so that each product fits in 2*DW + 1 bits
        pl2[k]  <= row1[k] * $signed({1'b0, cof1[3*k][DW-1:0]});
        ph2[k]  <= row1[k] * $signed(cof1[3*k][CFW-1:DW]);
      end
      det3     <= det_c;
      dneg     <= det3[DETW-1];
      dmag     <= dabs_c[DMW-1:0];
      singular <= (dabs_c == '0)
                  || (dabs_c < DETW'(threshold));
    end
  end

endmodule

[hw/rtl/minv_div_lane.sv]
// minv_div_lane: one lane of pipelined restoring division, rounding and saturation
// depends on nothing outside itself
module minv_div_lane #(
  parameter int DW = 24,
  parameter int FW = 16
) (
  input  logic              clk,
  input  logic              en,
  input  logic [2*DW-1:0]   cmag,
  input  logic              cneg,
  input  logic [3*DW-1:0]   dmag,
  input  logic              dneg,
  output logic [DW-1:0]     res,
  output logic              ovf
);

  localparam int CMW = 2*DW;
  localparam int DMW = 3*DW;
  localparam int NW  = CMW + 2*FW;
  localparam int CW  = ((NW > 4*DW) ? NW : 4*DW) + 1;
  localparam int STG = DW + 1;

  logic [CW-1:0]  rem [STG];
  logic [DMW-1:0] dv  [STG];
  logic [DW-1:0]  qt  [STG];
  logic           big [STG];
  logic           ng  [STG];

  logic [CW-1:0]  num0;
  logic [CW:0]    rem2;
  logic [DW:0]    qr;
  logic [DW:0]    bound;
  logic [DW:0]    mag;
  logic           neg_eff;
  logic           sat;

  assign num0 = CW'(cmag) << (2*FW);

  // first stage: quotient too large for DW bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num0;
      dv[0]  <= dmag;
      qt[0]  <= '0;
      big[0] <= num0 >= (CW'(dmag) << DW);
      ng[0]  <= cneg ^ dneg;
    end
  end

  for (genvar s = 1; s < STG; s++) begin : g_step
    localparam int J = DW - s;
    logic [CW-1:0] sub;
    logic          take;
    assign sub  = CW'(dv[s-1]) << J;
    assign take = rem[s-1] >= sub;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= take ? rem[s-1] - sub : rem[s-1];
        qt[s]  <= qt[s-1] | (take ? (DW'(1) << J) : '0);
        dv[s]  <= dv[s-1];
        big[s] <= big[s-1];
        ng[s]  <= ng[s-1];
      end
    end
  end

  // round half away from zero, then clamp to the signed range
  always_comb begin
    rem2    = {rem[STG-1], 1'b0};
    qr      = {1'b0, qt[STG-1]} + ((rem2 >= (CW+1)'(dv[STG-1])) ? (DW+1)'(1) : '0);
    neg_eff = ng[STG-1] && (big[STG-1] || (qr != '0));
    bound   = ((DW+1)'(1) << (DW-1)) - (DW+1)'(1) + (neg_eff ? (DW+1)'(1) : '0);
    sat     = big[STG-1] || (qr > bound);
    mag     = sat ? bound : qr;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= neg_eff ? DW'(-mag) : mag[DW-1:0];
      ovf <= sat;
    end
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking bench for matrix_inverse_3x3_core, with its own inverse predictor
// depends on minv_pkg and the core RTL; needs nothing else
module tb;

  localparam int DW   = 24;
  localparam int FB   = 16;
  localparam int LAT  = DW + 7;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 3 * LAT;
  localparam logic signed [DW-1:0] ONE  = 24'sd65536;
  localparam logic signed [DW-1:0] VMAX = 24'sh7fffff;
  localparam logic signed [DW-1:0] VMIN = 24'sh800000;

  typedef logic [8:0][DW-1:0] mat_t;
  typedef struct packed {
    mat_t e;
    logic singular;
    logic overflow;
  } inv_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  mat_t mat_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mat_t mat_out;
  logic singular, overflow;

  inv_t expected_q[$];
  logic [31:0] thr_mirror = minv_pkg::THR_RESET;
  int mismatches = 0;
  int cycles = 0;
  int hold_left = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int stall_pct = 0;
  int gap_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  matrix_inverse_3x3_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .a00(mat_in[0]), .a01(mat_in[1]), .a02(mat_in[2]),
    .a10(mat_in[3]), .a11(mat_in[4]), .a12(mat_in[5]),
    .a20(mat_in[6]), .a21(mat_in[7]), .a22(mat_in[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .r00(mat_out[0]), .r01(mat_out[1]), .r02(mat_out[2]),
    .r10(mat_out[3]), .r11(mat_out[4]), .r12(mat_out[5]),
    .r20(mat_out[6]), .r21(mat_out[7]), .r22(mat_out[8]),
    .singular(singular), .overflow(overflow)
  );

  // exact adjugate inverse: determinant and cofactors at full width, then
  // rounded division (ties away from zero) and saturation to DW bits
  function automatic inv_t predict_inverse(input mat_t a, input logic [31:0] thr);
    logic signed [127:0] m[9];
    logic signed [127:0] det, dmag, cof, n, q, r, lim, thr_w;
    logic neg;
    inv_t res;
    res = '0;
    for (int i = 0; i < 9; i++) m[i] = $signed(a[i]);
    det = 0;
    for (int k = 0; k < 3; k++)
      det += m[k] * (m[minv_pkg::COF_IDX[k*3][0]] * m[minv_pkg::COF_IDX[k*3][1]]
                   - m[minv_pkg::COF_IDX[k*3][2]] * m[minv_pkg::COF_IDX[k*3][3]]);
    dmag = (det < 0) ? -det : det;
    thr_w = $signed({96'd0, thr});
    // singular: zero determinant always, or below threshold
    if (dmag == 0 || dmag < thr_w) begin
      res.singular = 1'b1;
      return res;
    end
    for (int k = 0; k < 9; k++) begin
      cof = m[minv_pkg::COF_IDX[k][0]] * m[minv_pkg::COF_IDX[k][1]]
          - m[minv_pkg::COF_IDX[k][2]] * m[minv_pkg::COF_IDX[k][3]];
      neg = (cof < 0) ^ (det < 0);
      n = ((cof < 0) ? -cof : cof) <<< (2 * FB);
      q = n / dmag;
      r = n % dmag;
      if (2 * r >= dmag) q += 1;
      if (q == 0) neg = 1'b0;
      lim = (128'sd1 <<< (DW - 1)) - 1 + (neg ? 1 : 0);
      if (q > lim) begin
        q = lim;
        res.overflow = 1'b1;
      end
      if (neg) q = -q;
      res.e[k] = q[DW-1:0];
    end
    return res;
  endfunction

  // result checker: compares each output transaction with the oldest prediction
  always @(posedge clk) begin
    inv_t got, want;
    if (!rst && out_valid && out_ready) begin
      got.e = mat_out;
      got.singular = singular;
      got.overflow = overflow;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: singular exp %0b got %0b, overflow exp %0b got %0b",
                     want.singular, got.singular, want.overflow, got.overflow);
            for (int k = 0; k < 9; k++)
              if (got.e[k] !== want.e[k])
                $display("  r%0d%0d exp %0d got %0d", k / 3, k % 3,
                         $signed(want.e[k]), $signed(got.e[k]));
          end
        end
      end
    end
  end

  // receiver: long hold-off when requested, otherwise a random stall pattern
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  int burst_left = 0;

  // one input transaction; bursts of random length with random gaps between them;
  // valid stays high after acceptance so the next transaction can follow at once
  task automatic send_matrix(input mat_t a);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(99) < gap_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    mat_in <= a;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(predict_inverse(a, thr_mirror));
  endtask

  // threshold writes only with the pipeline drained
  task automatic write_threshold(input logic [31:0] v);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    thr_mirror = v;
  endtask

  function automatic mat_t diag(input logic signed [DW-1:0] d0, d1, d2);
    mat_t a;
    a = '0;
    a[0] = d0;
    a[4] = d1;
    a[8] = d2;
    return a;
  endfunction

  function automatic logic [DW-1:0] rand_entry();
    case ($urandom_range(3))
      0: rand_entry = DW'($urandom);
      1: rand_entry = DW'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
      2: rand_entry = DW'($signed($urandom_range(0, 1 << 10)) - (1 << 9));
      default: rand_entry = ($urandom_range(1)) ? DW'(VMAX - $urandom_range(3))
                                                 : DW'(VMIN + $urandom_range(3));
    endcase
  endfunction

  function automatic mat_t rand_matrix();
    mat_t a;
    for (int k = 0; k < 9; k++) a[k] = rand_entry();
    // sometimes make it exactly singular by repeating a row
    if ($urandom_range(9) == 0) begin
      a[6] = a[3];
      a[7] = a[4];
      a[8] = a[5];
    end
    return a;
  endfunction

  task automatic test_directed();
    mat_t a;
    send_matrix(diag(ONE, ONE, ONE));               // identity
    send_matrix(diag(-ONE, ONE, ONE));              // negative determinant
    send_matrix('0);                                // zero matrix, singular
    send_matrix(diag(DW'(2 * ONE), DW'(4 * ONE), ONE / 2));
    send_matrix(diag(1, 1, 1));                     // tiny entries, singular
    send_matrix(diag(1, ONE, ONE));                 // huge inverse, saturates
    send_matrix(diag(-1, ONE, ONE));                // negative saturation
    send_matrix(diag(VMAX, VMAX, VMAX));
    send_matrix(diag(VMIN, VMIN, VMIN));
    send_matrix(diag(DW'(3 * ONE), DW'(3 * ONE), DW'(3 * ONE)));   // inexact, rounding
    for (int k = 0; k < 9; k++) a[k] = VMAX;
    send_matrix(a);                                 // rank one
    for (int k = 0; k < 9; k++) a[k] = (k % 2) ? VMIN : VMAX;
    send_matrix(a);
    a = '{VMAX, VMIN, 0, 0, VMAX, VMIN, VMIN, 0, VMAX};
    send_matrix(a);
    a = '{ONE, DW'(2 * ONE), DW'(3 * ONE), 0, ONE, DW'(4 * ONE), DW'(5 * ONE),
          DW'(6 * ONE), 0};
    send_matrix(a);
    a = '{ONE, ONE, 0, 0, ONE, ONE, ONE, 0, ONE};
    send_matrix(a);
    send_matrix(diag(ONE, ONE, 24'sd17));           // small third entry, det well above threshold
  endtask

  task automatic test_threshold();
    write_threshold(32'd0);                         // only zero det singular
    send_matrix(diag(1, 1, 1));
    send_matrix('0);
    write_threshold(32'hffff_ffff);
    send_matrix(diag(1, ONE, ONE));
    send_matrix(diag(ONE, ONE, ONE));
    write_threshold(32'd1 << FB);
    send_matrix(diag(1, ONE, ONE));
    send_matrix(diag(1, ONE, 2));
    for (int i = 0; i < 20; i++) send_matrix(rand_matrix());
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) begin
        stall_pct = $urandom_range(0, 60);
        gap_pct = $urandom_range(0, 70);
      end
      send_matrix(rand_matrix());
    end
  endtask

  // receiver holds off long enough for the pipeline to fill and block the input
  task automatic test_backpressure();
    gap_pct = 0;
    hold_req++;
    for (int i = 0; i < 60; i++) send_matrix(rand_matrix());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_threshold();
    write_threshold(minv_pkg::THR_RESET);
    test_backpressure();
    test_random(300);
    write_threshold($urandom);
    test_random(150);
    write_threshold(minv_pkg::THR_RESET);
    stall_pct = 0;
    gap_pct = 0;
    test_random(150);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
